[hw/rtl/qcsu_pkg.sv]
// shared types, widths and helper functions of the quadratic spline upsampler
`timescale 1ns / 1ps
package qcsu_pkg;

  localparam int H_W         = 7;   // knot spacing width
  localparam int SPACING_MAX = 64;
  localparam int SPACING_RST = 10;
  localparam int GAIN_W      = 16;
  localparam int GAIN_RST    = 256;
  localparam int ELEV_W      = 24;
  localparam int Y_W         = 32;
  localparam int SLOPE_W     = 48;
  localparam int NUM_W       = 56;  // divider numerator, 16 fraction bits
  localparam int V_W         = 58;  // interpolation accumulator
  localparam int H2_W        = 13;  // h * h
  localparam int POS_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_STEPS   = 4;   // quotient bits per cycle

  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd1;

  typedef struct packed {
    logic load;   // latch the accepted input word
    logic scale;  // gain multiply, b*h, h*h, base position
    logic prep;   // form numerator and start division
    logic coef;   // take quotient as a or as the first slope
    logic slope;  // next slope and forward difference setup
    logic step;   // emit one interpolated point
    logic knot;   // emit the knot and update line state
  } ctrl_cmd_t;

  typedef struct packed {
    logic first_knot;
    logic h_one;
    logic t_last;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [SLOPE_W-1:0] sat_slope(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SLOPE_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      sat_slope = hi[SLOPE_W-1:0];
    end else if (v < lo) begin
      sat_slope = lo[SLOPE_W-1:0];
    end else begin
      sat_slope = v[SLOPE_W-1:0];
    end
  endfunction

  function automatic logic signed [Y_W-1:0] sat_height(input logic signed [V_W-17:0] v);
    logic upper_same;
    upper_same = (&v[V_W-17:Y_W-1]) | ~(|v[V_W-17:Y_W-1]);
    if (upper_same) begin
      sat_height = v[Y_W-1:0];
    end else if (v[V_W-17]) begin
      sat_height = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      sat_height = {1'b0, {(Y_W-1){1'b1}}};
    end
  endfunction

endpackage

[hw/rtl/quadratic_c1_spline_upsampler_core.sv]
// top level of the C1 quadratic spline upsampler
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    elevation, end_of_line
//   out       output     out_valid / out_ready  height, position, is_knot, last_of_run, line_done
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// the first knot of a line goes from accept through the scale state straight to its knot word
// later knots wait on the 4-bit-per-cycle coefficient divider, then one interpolated word per
// cycle while the output is free (none when h is 1) and the knot word last
// a stalled output holds the point generator; one word waits in the output register
// while the next knot is accepted; synchronous reset returns the spacing to 10, the gain
// to 1.0 and the line state to zero
`timescale 1ns / 1ps
module quadratic_c1_spline_upsampler_core #(
  parameter int MAX_KNOTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qcsu_pkg::ELEV_W-1:0]  elevation,
  input  logic                                end_of_line,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qcsu_pkg::Y_W-1:0]     height,
  output logic [qcsu_pkg::POS_W-1:0]          position,
  output logic                                is_knot,
  output logic                                last_of_run,
  output logic                                line_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qcsu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qcsu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  qcsu_pkg::ctrl_cmd_t  cmd;
  qcsu_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  qcsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  qcsu_dp #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .elevation   (elevation),
    .end_of_line (end_of_line),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .height      (height),
    .position    (position),
    .is_knot     (is_knot),
    .last_of_run (last_of_run),
    .line_done   (line_done)
  );

endmodule

[hw/rtl/qcsu_div.sv]
// radix-16 restoring divider for the spline coefficient, unsigned magnitudes
`timescale 1ns / 1ps
module qcsu_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [qcsu_pkg::NUM_W-1:0]    num,
  input  logic [qcsu_pkg::H2_W-1:0]     den,
  output logic                          done,
  output logic [qcsu_pkg::NUM_W-1:0]    quo
);

  localparam int NW    = qcsu_pkg::NUM_W;
  localparam int DW    = qcsu_pkg::H2_W;
  localparam int CYC   = NW / qcsu_pkg::DIV_STEPS;
  localparam int CNT_W = $clog2(CYC);

  logic [NW-1:0]    acc;
  logic [NW-1:0]    acc_next;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    rem_next;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt;
  logic             run;

  always_comb begin
    logic [DW:0] trial;
    acc_next = acc;
    rem_next = rem;
    for (int i = 0; i < qcsu_pkg::DIV_STEPS; i++) begin
      trial    = {rem_next, acc_next[NW-1]};
      acc_next = {acc_next[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_next    = DW'(trial - {1'b0, den_r});
        acc_next[0] = 1'b1;
      end else begin
        rem_next = trial[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CYC - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (run) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quo = acc;

endmodule

[hw/rtl/qcsu_ctrl.sv]
// sequencer for one knot: scale, divide, set up, emit points, emit knot; the first knot of a line skips to emit knot
`timescale 1ns / 1ps
module qcsu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qcsu_pkg::dp_status_t status,
  output qcsu_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCALE = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_COEF  = 8'b0001_0000,
    S_SLOPE = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_KNOT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = status.first_knot ? S_KNOT : S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_COEF;
        end
      end
      S_COEF: begin
        cmd.coef   = 1'b1;
        state_next = S_SLOPE;
      end
      S_SLOPE: begin
        cmd.slope  = 1'b1;
        state_next = status.h_one ? S_KNOT : S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.t_last) begin
            state_next = S_KNOT;
          end
        end
      end
      S_KNOT: begin
        if (status.out_free) begin
          cmd.knot   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/qcsu_dp.sv]
// datapath: config registers, scaling, coefficient math, point generator, output register
`timescale 1ns / 1ps
module qcsu_dp #(
  parameter int MAX_KNOTS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [qcsu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qcsu_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [qcsu_pkg::ELEV_W-1:0]    elevation,
  input  logic                                  end_of_line,
  input  logic                                  out_ready,
  input  qcsu_pkg::ctrl_cmd_t                   cmd,
  output qcsu_pkg::dp_status_t                  status,
  output logic                                  out_valid,
  output logic signed [qcsu_pkg::Y_W-1:0]       height,
  output logic [qcsu_pkg::POS_W-1:0]            position,
  output logic                                  is_knot,
  output logic                                  last_of_run,
  output logic                                  line_done
);

  localparam int KW  = $clog2(MAX_KNOTS);
  localparam int HW  = qcsu_pkg::H_W;
  localparam int YW  = qcsu_pkg::Y_W;
  localparam int SW  = qcsu_pkg::SLOPE_W;
  localparam int NW  = qcsu_pkg::NUM_W;
  localparam int VW  = qcsu_pkg::V_W;
  localparam int PW  = qcsu_pkg::POS_W;
  localparam int H2W = qcsu_pkg::H2_W;
  localparam int EW  = qcsu_pkg::ELEV_W;
  localparam int GW  = qcsu_pkg::GAIN_W;

  // configuration
  logic [HW-1:0]        spacing;
  logic signed [GW-1:0] gain;

  // per item
  logic signed [EW-1:0] elev_r;
  logic                 eol_r;
  logic [HW-1:0]        h_r;
  logic signed [YW-1:0] y_r;
  logic signed [NW-1:0] bh_r;
  logic [PW-1:0]        base_r;
  logic [H2W-1:0]       h2_r;
  logic                 neg_r;
  logic signed [NW-1:0] a_r;
  logic signed [SW-1:0] b_r;
  logic signed [SW-1:0] ns_r;
  logic signed [VW-1:0] v_r;
  logic signed [VW-1:0] d_r;
  logic [HW-1:0]        t_r;

  // line state
  logic signed [YW-1:0] prev_r;
  logic signed [SW-1:0] slope_r;
  logic [KW-1:0]        idx_r;

  logic [HW-1:0]        h_clamped;
  logic signed [EW+GW-1:0] prod;
  logic signed [NW-1:0] bh_w;
  logic signed [YW:0]   diff;
  logic signed [NW-1:0] num;
  logic [NW-1:0]        num_mag;
  logic [H2W-1:0]       den;
  logic                 div_done;
  logic [NW-1:0]        quo;
  logic signed [NW-1:0] q_s;
  logic signed [63:0]   ah;
  logic signed [63:0]   ns_wide;
  logic                 seg_one;
  logic                 done_line;
  logic                 out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= HW'(qcsu_pkg::SPACING_RST);
      gain    <= GW'(qcsu_pkg::GAIN_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qcsu_pkg::REG_SPACING: spacing <= cfg_data[HW-1:0];
        qcsu_pkg::REG_GAIN:    gain    <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (spacing == '0) begin
      h_clamped = HW'(1);
    end else if (spacing > HW'(qcsu_pkg::SPACING_MAX)) begin
      h_clamped = HW'(qcsu_pkg::SPACING_MAX);
    end else begin
      h_clamped = spacing;
    end
  end

  assign prod    = elev_r * gain;
  assign bh_w    = slope_r * $signed({1'b0, h_r});
  assign seg_one = (idx_r == KW'(1));
  assign diff    = {y_r[YW-1], y_r} - {prev_r[YW-1], prev_r};

  // numerator with 16 fraction bits: first segment divides by h, later ones by h*h
  always_comb begin
    if (seg_one) begin
      num = {{(NW-YW-17){diff[YW]}}, diff, 16'b0};
      den = H2W'(h_r);
    end else begin
      num = {{(NW-YW-16){y_r[YW-1]}}, y_r, 16'b0} - bh_r
          - {{(NW-YW-16){prev_r[YW-1]}}, prev_r, 16'b0};
      den = h2_r;
    end
    num_mag = num[NW-1] ? NW'(-num) : NW'(num);
  end

  qcsu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.prep),
    .num   (num_mag),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  assign q_s     = neg_r ? $signed(-quo) : $signed(quo);
  assign ah      = a_r * $signed({1'b0, h_r});
  assign ns_wide = (ah <<< 1) + {{(64-SW){b_r[SW-1]}}, b_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elev_r <= elevation;
      eol_r  <= end_of_line;
      h_r    <= h_clamped;
    end
    if (cmd.scale) begin
      y_r    <= prod[EW+GW-1:8];
      bh_r   <= bh_w;
      base_r <= PW'(idx_r) * PW'(h_r);
      h2_r   <= H2W'(h_r) * H2W'(h_r);
    end
    if (cmd.prep) begin
      neg_r <= num[NW-1];
    end
    if (cmd.coef) begin
      if (seg_one) begin
        a_r <= '0;
        b_r <= qcsu_pkg::sat_slope({{(64-NW){q_s[NW-1]}}, q_s});
      end else begin
        a_r <= q_s;
        b_r <= slope_r;
      end
    end
    // forward differences from t = 1: v = a + b + c, d = 3a + b, second difference 2a
    if (cmd.slope) begin
      ns_r <= qcsu_pkg::sat_slope(ns_wide);
      v_r  <= {{(VW-YW-16){prev_r[YW-1]}}, prev_r, 16'b0}
            + {{(VW-NW){a_r[NW-1]}}, a_r} + {{(VW-SW){b_r[SW-1]}}, b_r};
      d_r  <= {{(VW-NW){a_r[NW-1]}}, a_r} + {{(VW-NW-1){a_r[NW-1]}}, a_r, 1'b0}
            + {{(VW-SW){b_r[SW-1]}}, b_r};
      t_r  <= HW'(1);
    end else if (cmd.step) begin
      v_r <= v_r + d_r;
      d_r <= d_r + {{(VW-NW-1){a_r[NW-1]}}, a_r, 1'b0};
      t_r <= t_r + 1'b1;
    end
  end

  assign done_line = eol_r || (idx_r >= KW'(MAX_KNOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_r  <= '0;
      slope_r <= '0;
      idx_r   <= '0;
    end else if (cmd.knot) begin
      if (done_line) begin
        prev_r  <= '0;
        slope_r <= '0;
        idx_r   <= '0;
      end else begin
        if (idx_r != '0) begin
          slope_r <= ns_r;
        end
        prev_r <= y_r;
        idx_r  <= idx_r + 1'b1;
      end
    end
  end

  // output word register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step || cmd.knot) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      height      <= qcsu_pkg::sat_height(v_r[VW-1:16]);
      position    <= base_r + PW'(t_r);
      is_knot     <= 1'b0;
      last_of_run <= 1'b0;
      line_done   <= 1'b0;
    end else if (cmd.knot) begin
      height      <= y_r;
      position    <= base_r;
      is_knot     <= 1'b1;
      last_of_run <= 1'b1;
      line_done   <= done_line;
    end
  end

  assign status.first_knot = (idx_r == '0);
  assign status.h_one      = (h_r == HW'(1));
  assign status.t_last     = (t_r == h_r - 1'b1);
  assign status.div_done   = div_done;
  assign status.out_free   = out_free;

endmodule
